// File: hdl/mpq_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes of the min priority queue.
// No dependencies; used by every module of the block but mpq_ram.
package mpq_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int OCC_W    = 7;

	typedef logic [1:0]              cmd_t;
	typedef logic [1:0]              stat_t;
	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [ADDR_W-1:0]       addr_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	localparam cmd_t CMD_INSERT  = 2'd0;
	localparam cmd_t CMD_FIND    = 2'd1;
	localparam cmd_t CMD_EXTRACT = 2'd2;

	localparam stat_t ST_OK    = 2'd0;
	localparam stat_t ST_EMPTY = 2'd1;
	localparam stat_t ST_FULL  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic last_rd;
		logic last_wr;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic needs_scan;
		logic extract;
		logic scan_done;
	} sts_t;

endpackage

// File: hdl/mpq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/mpq_ctrl.sv
`timescale 1ns / 1ps
// Controller of the min priority queue: sequences accept, scan, move and result.
// Depends on mpq_pkg.
module mpq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mpq_pkg::sts_t sts,
	output mpq_pkg::ctl_t ctl
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_LAST_RD = 3'd2;
	localparam logic [2:0] S_LAST_WR = 3'd3;
	localparam logic [2:0] S_FINISH  = 3'd4;

	logic [2:0] state_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign out_valid = out_valid_q;

	always_comb begin
		ctl = '0;
		ctl.accept  = in_valid && in_ready;
		ctl.scan    = (state_q == S_SCAN);
		ctl.last_rd = (state_q == S_LAST_RD);
		ctl.last_wr = (state_q == S_LAST_WR);
		ctl.finish  = (state_q == S_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((ctl.accept && !sts.needs_scan) || ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (ctl.accept && sts.needs_scan) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.scan_done) begin
						state_q <= sts.extract ? S_LAST_RD : S_FINISH;
					end
				end
				S_LAST_RD: state_q <= S_LAST_WR;
				S_LAST_WR: state_q <= S_FINISH;
				S_FINISH: begin
					if (ctl.finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_scan_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept && sts.needs_scan |=> state_q == S_SCAN)
		else $error("scan did not start");
	a_finish_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> out_valid_q && state_q == S_IDLE)
		else $error("finished item not presented");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !ctl.accept)
		else $error("item accepted while busy");

endmodule

// File: hdl/mpq_dp.sv
`timescale 1ns / 1ps
// Datapath of the min priority queue: key RAM, count, minimum scan and result register.
// Depends on mpq_pkg and mpq_ram.
module mpq_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mpq_pkg::cmd_t         cmd,
	input  mpq_pkg::key_t         key,
	input  mpq_pkg::ctl_t         ctl,
	output mpq_pkg::sts_t         sts,
	output mpq_pkg::key_t         min_key,
	output mpq_pkg::stat_t        status,
	output logic [mpq_pkg::OCC_W-1:0] occupancy
);

	mpq_pkg::cnt_t  cnt_q;
	mpq_pkg::cnt_t  idx_q;
	mpq_pkg::cmd_t  cmd_q;
	mpq_pkg::key_t  best_key_q;
	mpq_pkg::addr_t best_slot_q;
	mpq_pkg::addr_t rd_idx_s1;
	logic           rd_vld_s1;
	mpq_pkg::key_t  min_key_q;
	mpq_pkg::stat_t status_q;
	logic [mpq_pkg::OCC_W-1:0] occ_q;

	logic           is_ins;
	logic           is_scan_cmd;
	logic           empty;
	logic           full;
	logic           issue;
	logic           ram_we;
	mpq_pkg::addr_t ram_waddr;
	logic [mpq_pkg::KEY_W-1:0] ram_wdata;
	mpq_pkg::addr_t ram_raddr;
	logic [mpq_pkg::KEY_W-1:0] ram_rdata;
	mpq_pkg::cnt_t  cnt_dec;
	mpq_pkg::key_t  rd_key;

	assign is_ins      = (cmd == mpq_pkg::CMD_INSERT);
	assign is_scan_cmd = (cmd == mpq_pkg::CMD_FIND) || (cmd == mpq_pkg::CMD_EXTRACT);
	assign empty       = (cnt_q == '0);
	assign full        = (cnt_q >= mpq_pkg::cnt_t'(mpq_pkg::CAPACITY));
	assign issue       = ctl.scan && (idx_q < cnt_q);
	assign cnt_dec     = cnt_q - mpq_pkg::cnt_t'(1);
	assign rd_key      = $signed(ram_rdata);

	assign sts.needs_scan = is_scan_cmd && !empty;
	assign sts.extract    = (cmd_q == mpq_pkg::CMD_EXTRACT);
	assign sts.scan_done  = (idx_q >= cnt_q) && !rd_vld_s1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[mpq_pkg::ADDR_W-1:0];
		ram_wdata = key;
		if (ctl.accept && is_ins && !full) begin
			ram_we = 1'b1;
		end else if (ctl.last_wr) begin
			ram_we    = 1'b1;
			ram_waddr = best_slot_q;
			ram_wdata = ram_rdata;
		end
		ram_raddr = ctl.last_rd ? cnt_dec[mpq_pkg::ADDR_W-1:0] : idx_q[mpq_pkg::ADDR_W-1:0];
	end

	mpq_ram #(
		.WIDTH (mpq_pkg::KEY_W),
		.DEPTH (mpq_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			cmd_q     <= mpq_pkg::CMD_INSERT;
		end else begin
			if (ctl.accept) begin
				cmd_q     <= cmd;
				idx_q     <= '0;
				rd_vld_s1 <= 1'b0;
				if (is_ins && !full) begin
					cnt_q <= cnt_q + mpq_pkg::cnt_t'(1);
				end
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + mpq_pkg::cnt_t'(1);
				end
				if (ctl.last_rd) begin
					cnt_q <= cnt_dec;
				end
			end
		end
	end

	// track the running minimum; strict compare keeps the first of equal keys
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[mpq_pkg::ADDR_W-1:0];
		if (rd_vld_s1 && ((rd_idx_s1 == '0) || (rd_key < best_key_q))) begin
			best_key_q  <= rd_key;
			best_slot_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && !sts.needs_scan) begin
			min_key_q <= '0;
			if (is_ins && full) begin
				status_q <= mpq_pkg::ST_FULL;
				occ_q    <= mpq_pkg::OCC_W'(cnt_q);
			end else if (is_ins) begin
				status_q <= mpq_pkg::ST_OK;
				occ_q    <= mpq_pkg::OCC_W'(cnt_q + mpq_pkg::cnt_t'(1));
			end else if (is_scan_cmd) begin
				status_q <= mpq_pkg::ST_EMPTY;
				occ_q    <= mpq_pkg::OCC_W'(cnt_q);
			end else begin
				status_q <= mpq_pkg::ST_OK;
				occ_q    <= mpq_pkg::OCC_W'(cnt_q);
			end
		end else if (ctl.finish) begin
			min_key_q <= best_key_q;
			status_q  <= mpq_pkg::ST_OK;
			occ_q     <= mpq_pkg::OCC_W'(cnt_q);
		end
	end

	assign min_key   = min_key_q;
	assign status    = status_q;
	assign occupancy = occ_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mpq_pkg::cnt_t'(mpq_pkg::CAPACITY))
		else $error("count exceeds capacity");
	a_extract_dec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.last_rd |=> cnt_q == $past(cnt_q) - mpq_pkg::cnt_t'(1))
		else $error("extract did not shrink the queue");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan |-> idx_q <= cnt_q)
		else $error("scan ran past the held keys");

endmodule

// File: hdl/min_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the min priority queue of signed 32-bit keys.
// Depends on mpq_pkg, mpq_ctrl and mpq_dp.
//
// Takes one command per item: insert, find minimum or extract minimum, with one
// result item per command. Insert, a find or extract on an empty queue, and an unused
// command register their result on acceptance, without a scan. Find and extract run a
// linear scan of the key RAM through its single registered read port, followed for
// extract by moving the last key into the freed slot. Holds up to CAPACITY keys; the
// key RAM needs no clearing after reset.
module min_priority_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mpq_pkg::cmd_t         cmd,
	input  mpq_pkg::key_t         key,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mpq_pkg::key_t         min_key,
	output mpq_pkg::stat_t        status,
	output logic [mpq_pkg::OCC_W-1:0] occupancy
);

	mpq_pkg::ctl_t ctl;
	mpq_pkg::sts_t sts;

	mpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	mpq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.key       (key),
		.ctl       (ctl),
		.sts       (sts),
		.min_key   (min_key),
		.status    (status),
		.occupancy (occupancy)
	);

endmodule
